@@ rtl/positional_linked_list_engine_unit_assert.svh @@
// Assertion macros for the linked list engine checker.
// Needs clk and arst_n in the scope of the user.
`ifndef POSITIONAL_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_UNIT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define PLLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("linked list engine check failed");

// consequent must hold in the same cycle as the antecedent
`define PLLE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("linked list engine check failed");

`endif

@@ rtl/plle_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the linked list engine.
// No dependencies.
package plle_pkg;

	localparam int FUNC_W = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W = 7;
	localparam int IN_W = 48;
	localparam int OUT_W = 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_INS_AT    = 3'd2,
		FN_DEL_FRONT = 3'd3,
		FN_DEL_BACK  = 3'd4,
		FN_DEL_AT    = 3'd5,
		FN_FIND      = 3'd6,
		FN_REVERSE   = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALLOC,
		ST_WALK_RD,
		ST_WALK_USE,
		ST_LINK_USE,
		ST_INS_FIX,
		ST_DEL_RD2,
		ST_DEL_USE2,
		ST_FIND_RD,
		ST_FIND_USE,
		ST_REV_RD,
		ST_REV_USE,
		ST_DONE
	} state_t;

endpackage

@@ rtl/plle_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module plle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/positional_linked_list_engine_unit.sv @@
`timescale 1ns / 1ps
// Linked list engine: front operations go from the check state straight to allocate (insert)
// or to a single link read (delete); position, back, find and reverse operations walk the list,
// a read state and a use state per node; one link store read per node paces the walk.
// One request in flight; s_tready rises in the same cycle as the result is presented on m_tvalid.
// arst_n clears the list to empty with all nodes free; no clearing pass.
module positional_linked_list_engine_unit
	import plle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // func[2:0], value[34:3], position[41:35], zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // success[0], found_position[7:1]
);

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int TW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	state_t st_q, st_d;
	func_t func_q, func_d;
	logic [VALUE_W-1:0] val_q, val_d;
	logic [TW-1:0] tgt_q, tgt_d, k_q, k_d;
	logic [IW-1:0] cur_q, cur_d, prev_q, prev_d, node_q, node_d, head_q, head_d;
	logic [IW-1:0] fc_q, fc_d, mark_q, mark_d, cnt_q, cnt_d;
	logic ok_q, ok_d;
	logic [POS_W-1:0] found_q, found_d;
	logic mv_q, mv_d;
	logic [OUT_W-1:0] md_q, md_d;

	logic lk_we, vl_we, fr_we;
	logic [AW-1:0] lk_wa, vl_wa, fr_wa;
	logic [IW-1:0] lk_wd, lk_rd, n_alloc, fc_m1;
	logic [AW-1:0] fr_wd, fr_rd;
	logic [VALUE_W-1:0] vl_rd;
	logic [TW-1:0] cnt_x, pos_in;
	logic is_ins;
	func_t func_in;

	assign fc_m1 = fc_q - IW'(1);
	assign cnt_x = TW'(cnt_q);
	assign func_in = func_t'(s_tdata[2:0]);
	assign pos_in = TW'(s_tdata[41:35]);
	assign is_ins = (func_q == FN_INS_FRONT) || (func_q == FN_INS_BACK) || (func_q == FN_INS_AT);
	assign n_alloc = (fc_q == mark_q) ? fc_m1 : IW'(fr_rd);

	plle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_values (
		.clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(val_q),
		.raddr(cur_q[AW-1:0]), .rdata(vl_rd)
	);

	plle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_links (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
		.raddr(cur_q[AW-1:0]), .rdata(lk_rd)
	);

	plle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
		.clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd),
		.raddr(fc_m1[AW-1:0]), .rdata(fr_rd)
	);

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = mv_q;
	assign m_tdata = md_q;

	always_comb begin
		st_d = st_q;
		func_d = func_q;
		val_d = val_q;
		tgt_d = tgt_q;
		k_d = k_q;
		cur_d = cur_q;
		prev_d = prev_q;
		node_d = node_q;
		head_d = head_q;
		fc_d = fc_q;
		mark_d = mark_q;
		cnt_d = cnt_q;
		ok_d = ok_q;
		found_d = found_q;
		mv_d = mv_q & ~m_tready;
		md_d = md_q;
		lk_we = 1'b0;
		lk_wa = cur_q[AW-1:0];
		lk_wd = prev_q;
		vl_we = 1'b0;
		vl_wa = n_alloc[AW-1:0];
		fr_we = 1'b0;
		fr_wa = fc_q[AW-1:0];
		fr_wd = cur_q[AW-1:0];
		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					func_d = func_in;
					val_d = s_tdata[34:3];
					case (func_in)
						FN_INS_FRONT, FN_DEL_FRONT: tgt_d = TW'(1);
						FN_INS_BACK: tgt_d = cnt_x + TW'(1);
						FN_DEL_BACK: tgt_d = cnt_x;
						default: tgt_d = pos_in;
					endcase
					st_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				ok_d = 1'b0;
				found_d = '0;
				cur_d = head_q;
				k_d = TW'(1);
				st_d = ST_DONE;
				if (is_ins) begin
					if (tgt_q != '0 && tgt_q <= cnt_x + TW'(1) && fc_q != '0) begin
						st_d = ST_ALLOC;
					end
				end else if (func_q == FN_FIND) begin
					if (cnt_q != '0) begin
						st_d = ST_FIND_RD;
					end
				end else if (func_q == FN_REVERSE) begin
					prev_d = NIL;
					k_d = '0;
					if (cnt_q != '0) begin
						st_d = ST_REV_RD;
					end
				end else if (tgt_q != '0 && tgt_q <= cnt_x) begin
					st_d = ST_WALK_RD;
				end
			end
			ST_ALLOC: begin
				node_d = n_alloc;
				vl_we = 1'b1;
				fc_d = fc_m1;
				if (fc_q == mark_q) begin
					mark_d = fc_m1;
				end
				if (tgt_q == TW'(1)) begin
					lk_we = 1'b1;
					lk_wa = n_alloc[AW-1:0];
					lk_wd = head_q;
					head_d = n_alloc;
					cnt_d = cnt_q + IW'(1);
					ok_d = 1'b1;
					st_d = ST_DONE;
				end else begin
					st_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				st_d = (k_q < tgt_q - TW'(1)) ? ST_WALK_USE : ST_LINK_USE;
			end
			ST_WALK_USE: begin
				cur_d = lk_rd;
				k_d = k_q + TW'(1);
				st_d = ST_WALK_RD;
			end
			ST_LINK_USE: begin
				if (is_ins) begin
					lk_we = 1'b1;
					lk_wa = node_q[AW-1:0];
					lk_wd = lk_rd;
					st_d = ST_INS_FIX;
				end else if (tgt_q == TW'(1)) begin
					head_d = lk_rd;
					if (fc_q < IW'(CAPACITY)) begin
						fr_we = 1'b1;
						fc_d = fc_q + IW'(1);
					end
					cnt_d = cnt_q - IW'(1);
					ok_d = 1'b1;
					st_d = ST_DONE;
				end else begin
					prev_d = cur_q;
					cur_d = lk_rd;
					st_d = ST_DEL_RD2;
				end
			end
			ST_INS_FIX: begin
				lk_we = 1'b1;
				lk_wd = node_q;
				cnt_d = cnt_q + IW'(1);
				ok_d = 1'b1;
				st_d = ST_DONE;
			end
			ST_DEL_RD2: begin
				st_d = ST_DEL_USE2;
			end
			ST_DEL_USE2: begin
				lk_we = 1'b1;
				lk_wa = prev_q[AW-1:0];
				lk_wd = lk_rd;
				if (fc_q < IW'(CAPACITY)) begin
					fr_we = 1'b1;
					fc_d = fc_q + IW'(1);
				end
				cnt_d = cnt_q - IW'(1);
				ok_d = 1'b1;
				st_d = ST_DONE;
			end
			ST_FIND_RD: begin
				st_d = ST_FIND_USE;
			end
			ST_FIND_USE: begin
				if (vl_rd == val_q) begin
					ok_d = 1'b1;
					found_d = k_q[POS_W-1:0];
					st_d = ST_DONE;
				end else if (k_q == cnt_x) begin
					st_d = ST_DONE;
				end else begin
					cur_d = lk_rd;
					k_d = k_q + TW'(1);
					st_d = ST_FIND_RD;
				end
			end
			ST_REV_RD: begin
				st_d = ST_REV_USE;
			end
			ST_REV_USE: begin
				lk_we = 1'b1;
				prev_d = cur_q;
				cur_d = lk_rd;
				k_d = k_q + TW'(1);
				if (k_q + TW'(1) == cnt_x) begin
					head_d = cur_q;
					ok_d = 1'b1;
					st_d = ST_DONE;
				end else begin
					st_d = ST_REV_RD;
				end
			end
			ST_DONE: begin
				if (!mv_q || m_tready) begin
					mv_d = 1'b1;
					md_d = {found_q, ok_q};
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			head_q <= NIL;
			fc_q <= IW'(CAPACITY);
			mark_q <= IW'(CAPACITY);
			cnt_q <= '0;
			mv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			head_q <= head_d;
			fc_q <= fc_d;
			mark_q <= mark_d;
			cnt_q <= cnt_d;
			mv_q <= mv_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d;
		val_q <= val_d;
		tgt_q <= tgt_d;
		k_q <= k_d;
		cur_q <= cur_d;
		prev_q <= prev_d;
		node_q <= node_d;
		ok_q <= ok_d;
		found_q <= found_d;
		md_q <= md_d;
	end

endmodule

@@ rtl/plle_chk.sv @@
`timescale 1ns / 1ps
// Port checker for the linked list engine, bound to the top level.
// Depends on positional_linked_list_engine_unit_assert.svh.
`include "positional_linked_list_engine_unit_assert.svh"
module plle_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	`PLLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`PLLE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`PLLE_ASSERT_NOW(a_found_ok, m_tvalid && m_tdata[7:1] != 7'd0, m_tdata[0])
	`PLLE_ASSERT_NEXT(a_one_result, m_tvalid && m_tready && s_tready, !m_tvalid)

endmodule

bind positional_linked_list_engine_unit plle_chk u_plle_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for positional_linked_list_engine_unit: random and directed
// list requests, each result checked against an in-bench model of the list.
// Depends on plle_pkg and the engine RTL.
module tb;
	import plle_pkg::*;

	localparam int CAP = 64;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	typedef struct packed {
		logic       ok;
		logic [6:0] pos;
	} outcome_t;

	logic [IN_W-1:0] pending_reqs[$];
	outcome_t        expected_outcomes[$];

	// list model: plain ordered array of values
	logic [31:0] list_vals[$];
	int errors;
	int accepted;
	int checked;
	int n_ok;
	bit quiet;

	// acceptance seen at the rising edge, used by the driver on the next fall
	logic s_tready_q;

	positional_linked_list_engine_unit #(.CAPACITY(CAP)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [IN_W-1:0] pack_req(func_t f, logic [31:0] v, logic [6:0] p);
		return {{(IN_W-42){1'b0}}, p, v, f};
	endfunction

	function automatic outcome_t apply_request(logic [IN_W-1:0] req);
		func_t       f;
		logic [31:0] v;
		int          p;
		int          cnt;
		outcome_t    r;
		f = func_t'(req[2:0]);
		v = req[34:3];
		p = req[41:35];
		cnt = list_vals.size();
		r = '0;
		case (f)
			FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
				if (f == FN_INS_FRONT) p = 1;
				if (f == FN_INS_BACK) p = cnt + 1;
				if (p >= 1 && p <= cnt + 1 && cnt < CAP) begin
					list_vals.insert(p - 1, v);
					r.ok = 1'b1;
				end
			end
			FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
				if (f == FN_DEL_FRONT) p = 1;
				if (f == FN_DEL_BACK) p = cnt;
				if (p >= 1 && p <= cnt) begin
					list_vals.delete(p - 1);
					r.ok = 1'b1;
				end
			end
			FN_FIND: begin
				for (int k = 0; k < cnt; k++)
					if (r.pos == 0 && list_vals[k] == v) r.pos = 7'(k + 1);
				r.ok = (r.pos != 0);
			end
			default: begin
				if (cnt > 0) begin
					for (int k = 0; k < cnt / 2; k++) begin
						logic [31:0] t;
						t = list_vals[k];
						list_vals[k] = list_vals[cnt-1-k];
						list_vals[cnt-1-k] = t;
					end
					r.ok = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("tb: mismatch %s at %0t: got %02h want %02h", what, $time, got, want);
		errors++;
	endtask

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || s_tready_q) begin
				if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 33)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_reqs.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= 33);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tready_q <= 1'b0;
		end else begin
			s_tready_q <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				expected_outcomes.push_back(apply_request(s_tdata));
				accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata, 8'h00);
				end else begin
					outcome_t e;
					e = expected_outcomes.pop_front();
					if (m_tdata[0] !== e.ok)
						report_mismatch("success", m_tdata, {e.pos, e.ok});
					if (m_tdata[7:1] !== e.pos)
						report_mismatch("found_position", m_tdata, {e.pos, e.ok});
					n_ok += e.ok;
					checked++;
				end
			end
		end
	end

	initial begin
		logic [IN_W-1:0] r;
		int fill;
		errors = 0;
		accepted = 0;
		checked = 0;
		n_ok = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		// directed: empty-list refusals, extremes, full list, range edges
		pending_reqs.push_back(pack_req(FN_DEL_FRONT, 0, 0));
		pending_reqs.push_back(pack_req(FN_DEL_BACK, 0, 0));
		pending_reqs.push_back(pack_req(FN_DEL_AT, 0, 1));
		pending_reqs.push_back(pack_req(FN_FIND, 0, 0));
		pending_reqs.push_back(pack_req(FN_REVERSE, 0, 0));
		pending_reqs.push_back(pack_req(FN_INS_AT, 32'h1, 0));
		pending_reqs.push_back(pack_req(FN_INS_AT, 32'h1, 2));
		pending_reqs.push_back(pack_req(FN_INS_AT, 32'h8000_0000, 1));
		pending_reqs.push_back(pack_req(FN_REVERSE, 0, 0));
		pending_reqs.push_back(pack_req(FN_INS_BACK, 32'h7fff_ffff, 7'h7f));
		pending_reqs.push_back(pack_req(FN_INS_FRONT, 32'hffff_ffff, 0));
		pending_reqs.push_back(pack_req(FN_INS_AT, 32'h5, 4));
		pending_reqs.push_back(pack_req(FN_FIND, 32'h7fff_ffff, 0));
		pending_reqs.push_back(pack_req(FN_FIND, 32'h1234, 0));
		pending_reqs.push_back(pack_req(FN_REVERSE, 0, 0));
		pending_reqs.push_back(pack_req(FN_DEL_AT, 0, 5));
		pending_reqs.push_back(pack_req(FN_DEL_AT, 0, 0));
		pending_reqs.push_back(pack_req(FN_DEL_AT, 0, 2));
		pending_reqs.push_back(pack_req(FN_DEL_BACK, 0, 0));
		for (int i = 0; i < 64; i++)
			pending_reqs.push_back(pack_req(FN_INS_BACK, 32'(i), 0));
		pending_reqs.push_back(pack_req(FN_INS_FRONT, 32'h9, 0));
		pending_reqs.push_back(pack_req(FN_INS_AT, 32'h9, 7'h7f));
		pending_reqs.push_back(pack_req(FN_REVERSE, 0, 0));
		pending_reqs.push_back(pack_req(FN_FIND, 32'h0, 0));
		pending_reqs.push_back(pack_req(FN_DEL_AT, 0, 7'h7f));
		pending_reqs.push_back(pack_req(FN_DEL_AT, 0, 64));
		// random requests in fill and drain phases; small values make find hits likely
		for (int i = 0; i < 1300; i++) begin
			func_t f;
			fill = $urandom_range(0, 99);
			f = func_t'($urandom_range(0, 7));
			if (i % 400 < 150 && fill < 40) f = func_t'($urandom_range(0, 2));
			if (i % 400 >= 250 && i % 400 < 330 && fill < 40) f = func_t'($urandom_range(3, 5));
			r = pack_req(f, $urandom, ($urandom_range(0, 3) == 0) ?
				7'($urandom) : 7'($urandom_range(0, 66)));
			if ($urandom_range(0, 1)) r[34:3] = 32'($urandom_range(0, 15));
			pending_reqs.push_back(r);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_reqs.size() == 0);
		wait (!s_tvalid);
		quiet = 1'b1;
		wait (expected_outcomes.size() == 0);
		repeat (200) @(posedge clk);
		$display("tb: %0d requests accepted, %0d results checked, %0d successful",
			accepted, checked, n_ok);
		$display("tb: covered all eight operations, full and empty list, range edges");
		if (errors == 0 && expected_outcomes.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// quiet stretch with no idling in the middle of the run
	initial begin
		wait (accepted == 600);
		quiet = 1'b1;
		wait (accepted == 800);
		quiet = 1'b0;
	end

	initial begin
		#20ms;
		$display("tb: timeout");
		$display("tb: done, errors");
		$finish;
	end

endmodule
